// ----- hw/rtl/fife_pkg.sv -----
// Shared types, codes and constants of the fade-in/fade-out envelope generator.
package fife_pkg;

  // Quotient bits produced by the fade ratio division
  localparam int unsigned DivSteps = 16;

  // Q1.16 value of one for the fade ratio
  localparam logic [16:0] RatioOne = 17'h10000;

  // Q8.8 value of one for the latched scale
  localparam logic [15:0] ScaleOne = 16'h0100;

  // Request codes
  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqTick  = 2'd1;
  localparam logic [1:0] ReqStop  = 2'd2;

  // Phase codes
  localparam logic [1:0] PhaseSteady  = 2'd0;
  localparam logic [1:0] PhaseFadeIn  = 2'd1;
  localparam logic [1:0] PhaseFadeOut = 2'd2;
  localparam logic [1:0] PhaseIdle    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgBaseDuration = 2'd0;
  localparam logic [1:0] CfgFadeInTime   = 2'd1;
  localparam logic [1:0] CfgFadeOutTime  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [19:0] delta_time;
    logic [16:0] dynamic_scale;
    logic [15:0] shake_scale;
    logic [31:0] duration_override;
    logic        stop_immediately;
  } in_item_t;

  typedef struct packed {
    logic [15:0] weight;
    logic        running;
    logic        done_res;
    logic [1:0]  phase;
  } out_item_t;

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_ADD_SAT,
    ALU_GE,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    logic        flag;
    logic [49:0] value;
  } alu_res_t;

endpackage

// ----- hw/rtl/fade_in_fade_out_envelope.sv -----
// Top level: sequencer, envelope state and result register around the shared unit.
// Sequence: start, stop, unused codes and ticks while idle go straight to the result register;
// a running tick steps through the timers, the compares, a restoring division of the fade
// ratio during a fade and up to three multiplies, all on the one shared arithmetic unit.
// Throughput: one transaction at a time; input ready returns once the result is registered.
// Reset: asynchronous active low; timers cleared, scale one, envelope idle, no result pending.
module fade_in_fade_out_envelope (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fife_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fife_pkg::out_item_t out_data_o
);

  localparam int unsigned CntWidth = $clog2(fife_pkg::DivSteps);
  localparam logic [CntWidth-1:0] DivLast = CntWidth'(fife_pkg::DivSteps - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ELAP   = 4'd1;
  localparam logic [3:0] ST_DUR    = 4'd2;
  localparam logic [3:0] ST_FADDI  = 4'd3;
  localparam logic [3:0] ST_FADDO  = 4'd4;
  localparam logic [3:0] ST_INCMP  = 4'd5;
  localparam logic [3:0] ST_OUTCMP = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_OUTMUL = 4'd8;
  localparam logic [3:0] ST_W1     = 4'd9;
  localparam logic [3:0] ST_W2     = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0]          state_q, state_d;
  logic [31:0]         base_dur_q, base_dur_d;
  logic [31:0]         fit_q, fit_d;
  logic [31:0]         fot_q, fot_d;
  logic [31:0]         elapsed_q, elapsed_d;
  logic [31:0]         fie_q, fie_d;
  logic [31:0]         foe_q, foe_d;
  logic [31:0]         act_dur_q, act_dur_d;
  logic [15:0]         scale_q, scale_d;
  logic                active_q, active_d;
  logic                finished_q, finished_d;
  logic                fin_q, fin_d;
  logic                fout_q, fout_d;
  logic [16:0]         ratio_q, ratio_d;
  logic [19:0]         delta_q, delta_d;
  logic [16:0]         alpha_q, alpha_d;
  logic [31:0]         rem_q, rem_d;
  logic [15:0]         quo_q, quo_d;
  logic [CntWidth-1:0] div_cnt_q, div_cnt_d;
  logic                div_out_q, div_out_d;
  logic [32:0]         prod_q, prod_d;
  logic [15:0]         weight_q, weight_d;
  logic                out_valid_q, out_valid_d;
  fife_pkg::out_item_t out_q, out_d;

  fife_pkg::alu_op_e   alu_op;
  logic [32:0]         alu_a;
  logic [32:0]         alu_b;
  fife_pkg::alu_res_t  alu_res;
  logic                running;

  fife_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign running     = active_q & ~finished_q;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequence one transaction through the shared unit
  always_comb begin
    state_d     = state_q;
    base_dur_d  = base_dur_q;
    fit_d       = fit_q;
    fot_d       = fot_q;
    elapsed_d   = elapsed_q;
    fie_d       = fie_q;
    foe_d       = foe_q;
    act_dur_d   = act_dur_q;
    scale_d     = scale_q;
    active_d    = active_q;
    finished_d  = finished_q;
    fin_d       = fin_q;
    fout_d      = fout_q;
    ratio_d     = ratio_q;
    delta_d     = delta_q;
    alpha_d     = alpha_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    div_out_d   = div_out_q;
    prod_d      = prod_q;
    weight_d    = weight_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    alu_op      = fife_pkg::ALU_ADD_SAT;
    alu_a       = '0;
    alu_b       = '0;

    // Write configuration registers
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fife_pkg::CfgBaseDuration: base_dur_d = cfg_wdata_i;
        fife_pkg::CfgFadeInTime:   fit_d      = cfg_wdata_i;
        fife_pkg::CfgFadeOutTime:  fot_d      = cfg_wdata_i;
        default: ;
      endcase
    end

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          weight_d = '0;
          delta_d  = in_data_i.delta_time;
          alpha_d  = in_data_i.dynamic_scale;
          state_d  = ST_DONE;
          case (in_data_i.req_type)
            fife_pkg::ReqStart: begin
              elapsed_d  = '0;
              fie_d      = '0;
              foe_d      = '0;
              active_d   = 1'b1;
              finished_d = 1'b0;
              fin_d      = (fit_q != '0);
              fout_d     = 1'b0;
              scale_d    = in_data_i.shake_scale;
              act_dur_d  = (in_data_i.duration_override != '0) ?
                           in_data_i.duration_override : base_dur_q;
            end
            fife_pkg::ReqStop: begin
              if (in_data_i.stop_immediately || (fot_q == '0)) begin
                active_d   = 1'b0;
                finished_d = 1'b1;
                fin_d      = 1'b0;
                fout_d     = 1'b0;
              end else if (!fout_q) begin
                fin_d  = 1'b0;
                fout_d = 1'b1;
                foe_d  = '0;
              end
            end
            fife_pkg::ReqTick: begin
              if (running) begin
                ratio_d = fife_pkg::RatioOne;
                state_d = ST_ELAP;
              end
            end
            default: ;
          endcase
        end
      end

      // Advance the elapsed timer
      ST_ELAP: begin
        alu_op    = fife_pkg::ALU_ADD_SAT;
        alu_a     = {1'b0, elapsed_q};
        alu_b     = {13'd0, delta_q};
        elapsed_d = alu_res.value[31:0];
        state_d   = ST_DUR;
      end

      // Once a nonzero duration is reached, stop at once without fade-out time, else begin a graceful stop
      ST_DUR: begin
        alu_op = fife_pkg::ALU_GE;
        alu_a  = {1'b0, elapsed_q};
        alu_b  = {1'b0, act_dur_q};
        if ((act_dur_q != '0) && alu_res.flag) begin
          if (fot_q == '0) begin
            active_d   = 1'b0;
            finished_d = 1'b1;
            fin_d      = 1'b0;
            fout_d     = 1'b0;
            ratio_d    = '0;
          end else if (!fout_q) begin
            fin_d  = 1'b0;
            fout_d = 1'b1;
            foe_d  = '0;
          end
        end
        state_d = ST_FADDI;
      end

      // Advance the fade-in timer
      ST_FADDI: begin
        alu_op = fife_pkg::ALU_ADD_SAT;
        alu_a  = {1'b0, fie_q};
        alu_b  = {13'd0, delta_q};
        if (fin_q) begin
          fie_d = alu_res.value[31:0];
        end
        state_d = ST_FADDO;
      end

      // Advance the fade-out timer
      ST_FADDO: begin
        alu_op = fife_pkg::ALU_ADD_SAT;
        alu_a  = {1'b0, foe_q};
        alu_b  = {13'd0, delta_q};
        if (fout_q) begin
          foe_d = alu_res.value[31:0];
        end
        state_d = ST_INCMP;
      end

      // End the fade-in or start its ratio division
      ST_INCMP: begin
        alu_op  = fife_pkg::ALU_GE;
        alu_a   = {1'b0, fie_q};
        alu_b   = {1'b0, fit_q};
        state_d = ST_OUTCMP;
        if (fin_q) begin
          if (alu_res.flag) begin
            fin_d = 1'b0;
            fie_d = fit_q;
          end else begin
            rem_d     = fie_q;
            quo_d     = '0;
            div_out_d = 1'b0;
            state_d   = ST_DIV;
          end
        end
      end

      // End the fade-out or start its ratio division
      ST_OUTCMP: begin
        alu_op  = fife_pkg::ALU_GE;
        alu_a   = {1'b0, foe_q};
        alu_b   = {1'b0, fot_q};
        state_d = ST_W1;
        if (fout_q) begin
          if (alu_res.flag) begin
            fout_d     = 1'b0;
            foe_d      = fot_q;
            active_d   = 1'b0;
            finished_d = 1'b1;
            ratio_d    = '0;
          end else begin
            rem_d     = foe_q;
            quo_d     = '0;
            div_out_d = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end

      // One restoring division step per cycle
      ST_DIV: begin
        alu_op = fife_pkg::ALU_GE;
        alu_a  = {rem_q, 1'b0};
        alu_b  = {1'b0, (div_out_q ? fot_q : fit_q)};
        rem_d  = alu_res.flag ? alu_res.value[31:0] : {rem_q[30:0], 1'b0};
        quo_d  = {quo_q[14:0], alu_res.flag};
        if (div_cnt_q == DivLast) begin
          div_cnt_d = '0;
          if (div_out_q) begin
            state_d = ST_OUTMUL;
          end else begin
            ratio_d = {1'b0, quo_d};
            state_d = ST_OUTCMP;
          end
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end

      // Scale the ratio by the fade-out fraction
      ST_OUTMUL: begin
        alu_op  = fife_pkg::ALU_MUL;
        alu_a   = {16'd0, ratio_q};
        alu_b   = {16'd0, (fife_pkg::RatioOne - {1'b0, quo_q})};
        ratio_d = alu_res.value[32:16];
        state_d = ST_W1;
      end

      // Ratio times latched scale
      ST_W1: begin
        alu_op = fife_pkg::ALU_MUL;
        alu_a  = {16'd0, ratio_q};
        alu_b  = {17'd0, scale_q};
        if (running) begin
          prod_d  = alu_res.value[32:0];
          state_d = ST_W2;
        end else begin
          weight_d = '0;
          state_d  = ST_DONE;
        end
      end

      // Times alpha, shift down and saturate
      ST_W2: begin
        alu_op   = fife_pkg::ALU_MUL;
        alu_a    = prod_q;
        alu_b    = {16'd0, alpha_q};
        weight_d = (alu_res.value[49:48] != 2'b00) ? 16'hFFFF : alu_res.value[47:32];
        state_d  = ST_DONE;
      end

      // Load the result register when free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.weight   = running ? weight_q : '0;
          out_d.running  = running;
          out_d.done_res = finished_q;
          if (!running) begin
            out_d.phase = fife_pkg::PhaseIdle;
          end else if (fin_q) begin
            out_d.phase = fife_pkg::PhaseFadeIn;
          end else if (fout_q) begin
            out_d.phase = fife_pkg::PhaseFadeOut;
          end else begin
            out_d.phase = fife_pkg::PhaseSteady;
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_dur_q  <= '0;
      fit_q       <= '0;
      fot_q       <= '0;
      elapsed_q   <= '0;
      fie_q       <= '0;
      foe_q       <= '0;
      act_dur_q   <= '0;
      scale_q     <= fife_pkg::ScaleOne;
      active_q    <= 1'b0;
      finished_q  <= 1'b0;
      fin_q       <= 1'b0;
      fout_q      <= 1'b0;
      div_cnt_q   <= '0;
      div_out_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_dur_q  <= base_dur_d;
      fit_q       <= fit_d;
      fot_q       <= fot_d;
      elapsed_q   <= elapsed_d;
      fie_q       <= fie_d;
      foe_q       <= foe_d;
      act_dur_q   <= act_dur_d;
      scale_q     <= scale_d;
      active_q    <= active_d;
      finished_q  <= finished_d;
      fin_q       <= fin_d;
      fout_q      <= fout_d;
      div_cnt_q   <= div_cnt_d;
      div_out_q   <= div_out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ratio_q  <= ratio_d;
    delta_q  <= delta_d;
    alpha_q  <= alpha_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    prod_q   <= prod_d;
    weight_q <= weight_d;
    out_q    <= out_d;
  end

  // Fade-in and fade-out never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(fin_q && fout_q))
    else $error("fade-in and fade-out both set");

  // A finished envelope is never active
  assert property (@(posedge clk_i) disable iff (!rst_ni) finished_q |-> !active_q)
    else $error("finished envelope still active");

  // Division counter idles at zero outside the division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DIV) |-> (div_cnt_q == '0))
    else $error("division counter left nonzero");

  // An accepted transaction drops ready on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held after accept");

  // A result that is not running carries zero weight and the idle phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.running) |->
    ((out_data_o.weight == '0) && (out_data_o.phase == fife_pkg::PhaseIdle)))
    else $error("idle result with weight or phase");

endmodule

// ----- hw/rtl/fife_alu.sv -----
// Shared arithmetic unit: saturating add, compare-subtract and multiply.
module fife_alu (
  input  fife_pkg::alu_op_e  op_i,
  input  logic [32:0]        a_i,
  input  logic [32:0]        b_i,
  output fife_pkg::alu_res_t res_o
);

  logic [32:0] sum;
  logic [33:0] diff;
  logic [49:0] prod;

  // Saturating add on the low 32 bits
  assign sum  = {1'b0, a_i[31:0]} + {1'b0, b_i[31:0]};
  // Full-width subtract, borrow gives the compare
  assign diff = {1'b0, a_i} - {1'b0, b_i};
  // 33 by 17 bit multiply
  assign prod = a_i * b_i[16:0];

  always_comb begin
    res_o = '0;
    case (op_i)
      fife_pkg::ALU_ADD_SAT: begin
        res_o.flag  = sum[32];
        res_o.value = {18'd0, (sum[32] ? 32'hFFFF_FFFF : sum[31:0])};
      end
      fife_pkg::ALU_GE: begin
        res_o.flag  = ~diff[33];
        res_o.value = {17'd0, diff[32:0]};
      end
      fife_pkg::ALU_MUL: begin
        res_o.flag  = 1'b0;
        res_o.value = prod;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule
